### hdl/minmax_calibrated_sensor_normalizer_macros.svh
// Assertion macros for the min/max calibrated sensor normaliser.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef MINMAX_CALIBRATED_SENSOR_NORMALIZER_MACROS_SVH
`define MINMAX_CALIBRATED_SENSOR_NORMALIZER_MACROS_SVH

// same-cycle implication
`define MCSN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define MCSN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### hdl/mcsn_pkg.sv
// Package for the min/max calibrated sensor normaliser.
// Field widths, request and status codes, register indexes, entry types.
// No dependencies.
`default_nettype none

package mcsn_pkg;

    localparam int DATA_W    = 12;
    localparam int SPAN_W    = DATA_W + 1;
    localparam int FS_W      = 15;
    localparam int PROD_W    = DATA_W + FS_W;
    localparam int CH_W      = 4;
    localparam int REQ_W     = 2;
    localparam int ST_W      = 2;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = FS_W;
    localparam int DIV_STEPS = FS_W;
    localparam int DIV_CNT_W = 4;

    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_UNCAL       = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_MEASURE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEED   = 1'b1;

    localparam logic [FS_W-1:0]   FULL_SCALE_RST = 15'd1000;
    localparam logic [DATA_W-1:0] MIN_SEED_RST   = 12'd1500;

    typedef struct packed {
        logic [DATA_W-1:0] max_v;
        logic [DATA_W-1:0] min_v;
    } trk_entry_t;

    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic [SPAN_W-1:0] span;
    } cal_entry_t;

endpackage

`default_nettype wire

### hdl/minmax_calibrated_sensor_normalizer.sv
// Top level of the min/max calibrated sensor normaliser.
// Depends on mcsn_pkg; checked by mcsn_checker (bound separately).
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: req_type; tdata: channel, sample
//  m_axis    out  m_axis_tvalid/tready       tuser: status; tdata: norm_value
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A measure reads the tables, clamps, multiplies, runs 15 divide steps and hands over;
// start and end walk every channel of the one-port tables; a bad channel skips to hand-over
// after accept, and a non-positive span skips to it after the check.
// s_axis_tready is high only between items, from the cycle the result appears;
// a waiting result holds the block in its hand-over state until m_axis takes it.
// Reset clears the table valid bits, so every table entry reads as zero until written.
`default_nettype none

module minmax_calibrated_sensor_normalizer #(
    parameter int NUM_CHANNELS = 12,
    parameter int SAMPLE_BITS  = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mcsn_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // channel, sample
    input  wire logic [mcsn_pkg::REQ_W-1:0]          s_axis_tuser,   // req_type
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [mcsn_pkg::OUT_DATA_W-1:0]          m_axis_tdata,   // norm_value, pad
    output logic [mcsn_pkg::ST_W-1:0]                m_axis_tuser,   // status
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mcsn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mcsn_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mcsn_pkg::*;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_CMP_W = 7;
    localparam logic [DATA_W-1:0] SMP_MASK = (SAMPLE_BITS >= DATA_W) ? {DATA_W{1'b1}} :
                                             DATA_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_SMP_RD   = 4'd2;
    localparam logic [3:0] S_SMP_WR   = 4'd3;
    localparam logic [3:0] S_END_RD   = 4'd4;
    localparam logic [3:0] S_END_WR   = 4'd5;
    localparam logic [3:0] S_MEAS_RD  = 4'd6;
    localparam logic [3:0] S_MEAS_CHK = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]               state_reg, state_next;
    logic [CH_IDX_W-1:0]      cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [FS_W-1:0]          full_scale_reg;
    logic [DATA_W-1:0]        min_seed_reg;
    logic                     out_vld_reg, out_vld_next;
    logic [FS_W-1:0]          out_val_reg, out_val_next;
    logic [ST_W-1:0]          out_st_reg, out_st_next;
    logic [FS_W-1:0]          res_val_reg, res_val_next;
    logic [ST_W-1:0]          res_st_reg, res_st_next;
    logic [CH_IDX_W-1:0]      ch_reg, ch_next;
    logic [DATA_W-1:0]        x_reg, x_next;
    logic [DATA_W-1:0]        diff_reg, diff_next;
    logic [DATA_W-1:0]        den_reg, den_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [FS_W-1:0]          qsh_reg, qsh_next;
    logic [NUM_CHANNELS-1:0]  trk_vld_reg, cal_vld_reg;

    trk_entry_t               trk_mem [NUM_CHANNELS];
    cal_entry_t               cal_mem [NUM_CHANNELS];
    trk_entry_t               trk_rd_reg, trk_rd, trk_wdata;
    cal_entry_t               cal_rd_reg, cal_rd, cal_wdata;
    logic                     trk_rv_reg, cal_rv_reg;
    logic                     trk_we, cal_we;
    logic [CH_IDX_W-1:0]      rd_addr, wr_addr;

    logic                     in_acc;
    logic [REQ_W-1:0]         in_req;
    logic [CH_CMP_W-1:0]      in_ch_wide;
    logic                     in_ch_ok;
    logic [DATA_W-1:0]        lo, hi, xc;
    logic [PROD_W-1:0]        prod;
    logic [DATA_W+1:0]        trial;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_req        = s_axis_tuser;
    assign in_ch_wide    = {{(CH_CMP_W - CH_W){1'b0}}, s_axis_tdata[CH_W-1:0]};
    assign in_ch_ok      = in_ch_wide < CH_CMP_W'(NUM_CHANNELS);

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - FS_W){1'b0}}, out_val_reg};
    assign m_axis_tuser  = out_st_reg;

    assign trk_rd  = trk_rv_reg ? trk_rd_reg : '0;
    assign cal_rd  = cal_rv_reg ? cal_rd_reg : '0;
    assign rd_addr = (state_reg == S_END_RD) ? cnt_reg : ch_reg;
    assign wr_addr = (state_reg == S_SMP_WR) ? ch_reg : cnt_reg;
    assign trk_we  = (state_reg == S_CLR) || (state_reg == S_SMP_WR);
    assign cal_we  = (state_reg == S_END_WR);

    always_comb
    begin
        trk_wdata.max_v = '0;
        trk_wdata.min_v = min_seed_reg;
        if (state_reg == S_SMP_WR)
        begin
            trk_wdata.max_v = (x_reg > trk_rd.max_v) ? x_reg : trk_rd.max_v;
            trk_wdata.min_v = (x_reg < trk_rd.min_v) ? x_reg : trk_rd.min_v;
        end
        cal_wdata.offset = trk_rd.min_v;
        cal_wdata.span   = {1'b0, trk_rd.max_v} - {1'b0, trk_rd.min_v};
    end

    // clamp of the sample to the latched bounds
    assign lo    = cal_rd.offset;
    assign hi    = lo + cal_rd.span[DATA_W-1:0];
    always_comb
    begin
        xc = (x_reg >= hi) ? hi : x_reg;
        xc = (xc <= lo) ? lo : xc;
    end

    assign prod  = {{FS_W{1'b0}}, diff_reg} * {{DATA_W{1'b0}}, full_scale_reg};
    assign trial = {1'b0, rem_reg, qsh_reg[FS_W-1]} - {2'b00, den_reg};

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        div_cnt_next = div_cnt_reg;
        out_vld_next = out_vld_reg && !m_axis_tready;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        ch_next      = ch_reg;
        x_next       = x_reg;
        diff_next    = diff_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        qsh_next     = qsh_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ch_next      = in_ch_wide[CH_IDX_W-1:0];
                    x_next       = s_axis_tdata[CH_W +: DATA_W] & SMP_MASK;
                    res_val_next = '0;
                    res_st_next  = ST_NOT_MEASURE;
                    cnt_next     = '0;
                    case (in_req)
                        REQ_START:  state_next = S_CLR;
                        REQ_SAMPLE: state_next = in_ch_ok ? S_SMP_RD : S_DONE;
                        REQ_END:    state_next = S_END_RD;
                        REQ_MEASURE:
                        begin
                            res_st_next = ST_UNCAL;
                            state_next  = in_ch_ok ? S_MEAS_RD : S_DONE;
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_CLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CH)
                    state_next = S_DONE;
            end
            S_SMP_RD:  state_next = S_SMP_WR;
            S_SMP_WR:  state_next = S_DONE;
            S_END_RD:  state_next = S_END_WR;
            S_END_WR:
            begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = (cnt_reg == LAST_CH) ? S_DONE : S_END_RD;
            end
            S_MEAS_RD: state_next = S_MEAS_CHK;
            S_MEAS_CHK:
            begin
                if (cal_rd.span[SPAN_W-1] || (cal_rd.span == '0))
                    state_next = S_DONE;
                else
                begin
                    res_st_next = ST_OK;
                    diff_next   = xc - lo;
                    den_next    = cal_rd.span[DATA_W-1:0];
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                // quotient is below 2^FS_W, so the upper product bits start below the divisor
                rem_next     = prod[PROD_W-1:FS_W];
                qsh_next     = prod[FS_W-1:0];
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (trial[DATA_W+1])
                begin
                    rem_next = {rem_reg[DATA_W-2:0], qsh_reg[FS_W-1]};
                    qsh_next = {qsh_reg[FS_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[DATA_W-1:0];
                    qsh_next = {qsh_reg[FS_W-2:0], 1'b1};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    res_val_next = qsh_next;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next = 1'b1;
                    out_val_next = res_val_reg;
                    out_st_next  = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            div_cnt_reg    <= '0;
            out_vld_reg    <= 1'b0;
            full_scale_reg <= FULL_SCALE_RST;
            min_seed_reg   <= MIN_SEED_RST;
            trk_vld_reg    <= '0;
            cal_vld_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            div_cnt_reg <= div_cnt_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FULL_SCALE)
                    full_scale_reg <= cfg_data;
                if (cfg_index == REG_MIN_SEED)
                    min_seed_reg <= cfg_data[DATA_W-1:0];
            end
            if (trk_we)
                trk_vld_reg[wr_addr] <= 1'b1;
            if (cal_we)
                cal_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        ch_reg      <= ch_next;
        x_reg       <= x_next;
        diff_reg    <= diff_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        qsh_reg     <= qsh_next;
    end

    // channel tables: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        trk_rd_reg <= trk_mem[rd_addr];
        trk_rv_reg <= trk_vld_reg[rd_addr];
        cal_rd_reg <= cal_mem[rd_addr];
        cal_rv_reg <= cal_vld_reg[rd_addr];
        if (trk_we)
            trk_mem[wr_addr] <= trk_wdata;
        if (cal_we)
            cal_mem[wr_addr] <= cal_wdata;
    end

endmodule

`default_nettype wire

### hdl/mcsn_checker.sv
// Port checker for the min/max calibrated sensor normaliser, with its bind.
// Depends on mcsn_pkg and minmax_calibrated_sensor_normalizer_macros.svh.
`default_nettype none
`include "minmax_calibrated_sensor_normalizer_macros.svh"

module mcsn_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [mcsn_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic [mcsn_pkg::ST_W-1:0]         m_axis_tuser
);
    import mcsn_pkg::*;

    // stalled result holds
    `MCSN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // anything but a good measure carries a zero value
    `MCSN_ASSERT_SAME(a_zero_on_fail, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)

    // one item at a time
    `MCSN_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a result only appears out of a busy period
    `MCSN_ASSERT_SAME(a_result_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind minmax_calibrated_sensor_normalizer mcsn_checker u_mcsn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for minmax_calibrated_sensor_normalizer.
// Drives calibration and measure items over the stream ports with random idling, and config writes.
// Depends on mcsn_pkg and the top level only.
`default_nettype none

module testbench;
    import mcsn_pkg::*;

    localparam int CH_COUNT    = 12;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 212;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [FS_W-1:0] norm;
        logic [ST_W-1:0] status;
    } reading_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] smp;
        logic              fixed;
        logic [FS_W-1:0]   norm;
        logic [ST_W-1:0]   status;
    } stim_row_t;

    localparam stim_row_t DIRECTED [26] = '{
        '{REQ_MEASURE, 4'd0,  12'd0,    1'b1, 15'd0,          ST_UNCAL},
        '{REQ_END,     4'd0,  12'd0,    1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_MEASURE, 4'd11, 12'd4095, 1'b1, 15'd0,          ST_UNCAL},
        '{REQ_START,   4'd0,  12'd0,    1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_END,     4'd15, 12'd4095, 1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_MEASURE, 4'd3,  12'd2000, 1'b1, 15'd0,          ST_UNCAL},
        '{REQ_START,   4'd15, 12'd4095, 1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd0,  12'd100,  1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd0,  12'd3000, 1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd11, 12'd0,    1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd11, 12'd4095, 1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd15, 12'd4095, 1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd12, 12'd0,    1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_SAMPLE,  4'd5,  12'd2000, 1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_END,     4'd0,  12'd0,    1'b1, 15'd0,          ST_NOT_MEASURE},
        '{REQ_MEASURE, 4'd0,  12'd3000, 1'b1, FULL_SCALE_RST, ST_OK},
        '{REQ_MEASURE, 4'd0,  12'd100,  1'b1, 15'd0,          ST_OK},
        '{REQ_MEASURE, 4'd0,  12'd0,    1'b1, 15'd0,          ST_OK},
        '{REQ_MEASURE, 4'd0,  12'd4095, 1'b1, FULL_SCALE_RST, ST_OK},
        '{REQ_MEASURE, 4'd0,  12'd1550, 1'b0, 15'd0,          ST_OK},
        '{REQ_MEASURE, 4'd11, 12'd4095, 1'b1, FULL_SCALE_RST, ST_OK},
        '{REQ_MEASURE, 4'd11, 12'd2048, 1'b0, 15'd0,          ST_OK},
        '{REQ_MEASURE, 4'd12, 12'd1000, 1'b1, 15'd0,          ST_UNCAL},
        '{REQ_MEASURE, 4'd15, 12'd4095, 1'b1, 15'd0,          ST_UNCAL},
        '{REQ_MEASURE, 4'd1,  12'd100,  1'b1, 15'd0,          ST_UNCAL},
        '{REQ_MEASURE, 4'd5,  12'd1750, 1'b0, 15'd0,          ST_OK}
    };

    // -1: pick at random
    localparam int FS_PLAN   [PHASES] = '{1000, 32767, 1, 0, -1, -1, 32767, -1};
    localparam int SEED_PLAN [PHASES] = '{1500, 0, 4095, -1, -1, 4095, 1500, -1};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // channel, sample
    logic [REQ_W-1:0]      s_axis_tuser = '0;    // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // norm_value, pad
    logic [ST_W-1:0]       m_axis_tuser;         // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [FS_W-1:0]          fs_reg = FULL_SCALE_RST;
    logic [DATA_W-1:0]        seed_reg = MIN_SEED_RST;
    logic [DATA_W-1:0]        trk_hi [CH_COUNT];
    logic [DATA_W-1:0]        trk_lo [CH_COUNT];
    logic [DATA_W-1:0]        cal_lo [CH_COUNT];
    logic signed [SPAN_W-1:0] cal_width [CH_COUNT];

    reading_t readings_due [$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       gap_pct = 0;
    int       stall_pct = 0;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    int       cycle_count = 0;

    minmax_calibrated_sensor_normalizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < CH_COUNT; i++)
        begin
            trk_hi[i]    = '0;
            trk_lo[i]    = '0;
            cal_lo[i]    = '0;
            cal_width[i] = '0;
        end
    end

    function automatic reading_t normalise_step(logic [REQ_W-1:0] req, logic [CH_W-1:0] ch,
                                                logic [DATA_W-1:0] smp);
        reading_t          r;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] x;
        logic [31:0]       prod;
        r.norm   = '0;
        r.status = ST_NOT_MEASURE;
        case (req)
            REQ_START:
                for (int i = 0; i < CH_COUNT; i++)
                begin
                    trk_hi[i] = '0;
                    trk_lo[i] = seed_reg;
                end
            REQ_SAMPLE:
                if (ch < CH_COUNT)
                begin
                    if (smp > trk_hi[ch])
                        trk_hi[ch] = smp;
                    if (smp < trk_lo[ch])
                        trk_lo[ch] = smp;
                end
            REQ_END:
                for (int i = 0; i < CH_COUNT; i++)
                begin
                    cal_lo[i]    = trk_lo[i];
                    cal_width[i] = $signed({1'b0, trk_hi[i]}) - $signed({1'b0, trk_lo[i]});
                end
            default:
            begin
                r.status = ST_UNCAL;
                if (ch < CH_COUNT && cal_width[ch] > 0)
                begin
                    lo = cal_lo[ch];
                    hi = lo + cal_width[ch][DATA_W-1:0];
                    x  = smp;
                    if (x >= hi)
                        x = hi;
                    if (x <= lo)
                        x = lo;
                    prod     = 32'(x - lo) * 32'(fs_reg);
                    r.norm   = FS_W'(prod / 32'(cal_width[ch]));
                    r.status = ST_OK;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_item(logic [REQ_W-1:0] req, logic [CH_W-1:0] ch, logic [DATA_W-1:0] smp,
                             logic fixed = 1'b0, reading_t fixed_val = '0);
        reading_t r;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {smp, ch};
        do @(posedge clk); while (!s_axis_tready);
        r = normalise_step(req, ch, smp);
        readings_due.push_back(fixed ? fixed_val : r);
        items_sent++;
    endtask

    task automatic wait_all_back();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (readings_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_FULL_SCALE)
            fs_reg = val;
        else
            seed_reg = val[DATA_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(19) == 0)
            send_item(REQ_W'($urandom), CH_W'($urandom), DATA_W'($urandom));
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        if ($urandom_range(11) == 0)
            return CH_W'($urandom_range(15, CH_COUNT));
        return CH_W'($urandom_range(CH_COUNT - 1));
    endfunction

    function automatic logic [DATA_W-1:0] clamp_sample(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return DATA_W'(v);
    endfunction

    // start, a burst of samples, end, then measures around the calibrated window
    task automatic run_cal_round();
        int centre;
        int spread;
        int v;
        centre = int'($urandom_range(4095));
        spread = ($urandom_range(1) == 1) ? int'($urandom_range(64)) : int'($urandom_range(2047));
        maybe_noise();
        send_item(REQ_START, CH_W'($urandom), DATA_W'($urandom));
        repeat ($urandom_range(40, 4))
        begin
            v = centre + int'($urandom_range(2 * spread)) - spread;
            send_item(REQ_SAMPLE, pick_channel(), clamp_sample(v));
            maybe_noise();
        end
        send_item(REQ_END, CH_W'($urandom), DATA_W'($urandom));
        repeat ($urandom_range(50, 10))
        begin
            if ($urandom_range(9) < 7)
                v = centre + int'($urandom_range(3 * spread + 2)) - (3 * spread + 2) / 2;
            else
                v = int'($urandom_range(4095));
            send_item(REQ_MEASURE, pick_channel(), clamp_sample(v));
            maybe_noise();
        end
    endtask

    // result sink with random stalls and an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (readings_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: norm %0d status %0d",
                             m_axis_tdata[FS_W-1:0], m_axis_tuser);
            end
            else
            begin
                want = readings_due.pop_front();
                if (m_axis_tdata[FS_W-1:0] !== want.norm || m_axis_tuser !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: norm exp %0d got %0d, status exp %0d got %0d",
                                 want.norm, m_axis_tdata[FS_W-1:0], want.status, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int target;
        int fs_next;
        int seed_next;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_item(DIRECTED[i].req, DIRECTED[i].ch, DIRECTED[i].smp, DIRECTED[i].fixed,
                      '{norm: DIRECTED[i].norm, status: DIRECTED[i].status});

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_all_back();
                fs_next   = (FS_PLAN[p] < 0) ? int'($urandom_range(32767, 1)) : FS_PLAN[p];
                seed_next = (SEED_PLAN[p] < 0) ? int'($urandom_range(4095)) : SEED_PLAN[p];
                write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs_next));
                write_reg(REG_MIN_SEED, CFG_DATA_W'(seed_next));
            end
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 9; stall_pct = 9; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                run_cal_round();
                if (p % 4 == 0 && hold_requests == hold_served && hold_left == 0)
                    hold_requests++;
                if ($urandom_range(3) == 0)
                    wait_all_back();
            end
        end

        wait_all_back();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
